### hdl/kufs_pkg.sv
// Shared types and field widths for the union-find edge stream unit.
`default_nettype none
package kufs_pkg;

  localparam int VERTEX_W = 7;
  localparam int COST_W   = 16;
  localparam int TOTAL_W  = 23;
  localparam int COUNT_W  = 7;
  localparam int VCOUNT_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 8'd128;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_WALK_A,
    ST_WALK_B,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### hdl/kufs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module kufs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/kruskal_union_find_edge_stream_unit.sv
// Union-find edge stream unit: spanning forest, running cost and tree edge count per edge.
//
// The user must send edges sorted by cost (the unit does not check this); each
// endpoint is walked to its root through the parent RAM (one entry per vertex,
// root flag plus parent index), one RAM read per step, and an edge joining two
// roots links the first root under the second. An edge passes through ST_START,
// ST_WALK_A, ST_WALK_B and ST_DONE (an edge with a bad vertex goes from ST_START
// straight to ST_DONE), and the next edge is taken only back in ST_IDLE; the walks
// through the single RAM read port set how long an edge holds the unit. After
// reset, and on every edge with first_edge set before its walks, a clearing pass
// writes all MAX_VERTICES entries as roots, one per cycle, while no edge is taken.
// A finished result waits in the output register while the next edge is accepted;
// a second finished result holds the unit until the first has left.
`default_nettype none
module kruskal_union_find_edge_stream_unit
  import kufs_pkg::*;
#(
  parameter int MAX_VERTICES = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [VCOUNT_W-1:0]   cfg_wr_data,   // vertex_count
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,      // vertex_a, vertex_b, edge_cost, pad
  input  wire logic [0:0]            in_tuser,      // first_edge
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata      // accepted, total_cost, tree_edges,
                                                    // bad_vertex
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = (AW + 1 > VCOUNT_W) ? AW + 1 : VCOUNT_W;
  localparam int EW = AW + 1;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               clr_idx_r, clr_idx_nxt;
  logic                        item_r, item_nxt;
  logic [VERTEX_W-1:0]         va_r, va_nxt, vb_r, vb_nxt;
  logic signed [COST_W-1:0]    cost_r, cost_nxt;
  logic [AW-1:0]               node_r, node_nxt;
  logic [AW-1:0]               ra_r, ra_nxt;
  logic [TOTAL_W-1:0]          cost_sum_r, cost_sum_nxt;
  logic [COUNT_W-1:0]          edge_count_r, edge_count_nxt;
  logic                        acc_r, acc_nxt, bad_r, bad_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]       out_data_r, out_data_nxt;
  logic [VCOUNT_W-1:0]         vertex_count_r;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [EW-1:0]               mem_wdata;
  logic [EW-1:0]               mem_rdata;
  logic                        rd_root;
  logic [AW-1:0]               rd_parent;
  logic [CW-1:0]               va_ext, vb_ext, limit_ext, max_ext;
  logic                        va_ok, vb_ok;

  kufs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_VERTICES)
  ) u_parent_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (node_nxt),
    .rd_data (mem_rdata)
  );

  assign rd_root   = mem_rdata[AW];
  assign rd_parent = mem_rdata[AW-1:0];

  assign va_ext    = CW'(va_r);
  assign vb_ext    = CW'(vb_r);
  assign limit_ext = CW'(vertex_count_r);
  assign max_ext   = CW'(MAX_VERTICES);
  assign va_ok     = (va_ext < limit_ext) && (va_ext < max_ext);
  assign vb_ok     = (vb_ext < limit_ext) && (vb_ext < max_ext);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    item_nxt       = item_r;
    va_nxt         = va_r;
    vb_nxt         = vb_r;
    cost_nxt       = cost_r;
    node_nxt       = node_r;
    ra_nxt         = ra_r;
    cost_sum_nxt   = cost_sum_r;
    edge_count_nxt = edge_count_r;
    acc_nxt        = acc_r;
    bad_nxt        = bad_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx_r;
    mem_wdata      = {1'b1, {AW{1'b0}}};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(MAX_VERTICES - 1)) begin
          clr_idx_nxt = '0;
          state_nxt   = item_r ? ST_START : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          va_nxt   = in_tdata[VERTEX_W-1:0];
          vb_nxt   = in_tdata[2*VERTEX_W-1:VERTEX_W];
          cost_nxt = in_tdata[2*VERTEX_W+COST_W-1:2*VERTEX_W];
          item_nxt = 1'b1;
          if (in_tuser[0]) begin
            cost_sum_nxt   = '0;
            edge_count_nxt = '0;
            clr_idx_nxt    = '0;
            state_nxt      = ST_CLEAR;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        acc_nxt = 1'b0;
        if (!(va_ok && vb_ok)) begin
          bad_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          bad_nxt   = 1'b0;
          node_nxt  = va_ext[AW-1:0];
          state_nxt = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (rd_root) begin
          ra_nxt    = node_r;
          node_nxt  = vb_ext[AW-1:0];
          state_nxt = ST_WALK_B;
        end else begin
          node_nxt = rd_parent;
        end
      end
      ST_WALK_B: begin
        if (rd_root) begin
          if (node_r != ra_r) begin
            mem_we         = 1'b1;
            mem_waddr      = ra_r;
            mem_wdata      = {1'b0, node_r};
            cost_sum_nxt   = cost_sum_r + TOTAL_W'(cost_r);
            edge_count_nxt = edge_count_r + 1'b1;
            acc_nxt        = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          node_nxt = rd_parent;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {bad_r, edge_count_r, cost_sum_r, acc_r};
          item_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_idx_r      <= '0;
      item_r         <= 1'b0;
      cost_sum_r     <= '0;
      edge_count_r   <= '0;
      out_valid_r    <= 1'b0;
      vertex_count_r <= VCOUNT_RESET;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      item_r       <= item_nxt;
      cost_sum_r   <= cost_sum_nxt;
      edge_count_r <= edge_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        vertex_count_r <= cfg_wr_data;
      end
    end
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    cost_r     <= cost_nxt;
    node_r     <= node_nxt;
    ra_r       <= ra_nxt;
    acc_r      <= acc_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  a_no_item_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !item_r)
    else $error("edge pending while input is ready");

  a_accept_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[OUT_DATA_W-1]))
    else $error("result both accepted and bad");

  a_link_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_WALK_B) |=> edge_count_r == $past(edge_count_r) + 1'b1)
    else $error("link without edge count advance");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_WALK_B))
    else $error("parent write outside clear or link");

endmodule
`default_nettype wire
